>>> rtl/u8v_pkg.sv
`timescale 1ns / 1ps

package u8v_pkg;

    localparam logic [2:0] CHK_NONE = 3'd0;
    localparam logic [2:0] CHK_E0   = 3'd1;
    localparam logic [2:0] CHK_ED   = 3'd2;
    localparam logic [2:0] CHK_F0   = 3'd3;
    localparam logic [2:0] CHK_F4   = 3'd4;

    localparam logic [7:0] BYTE_ASCII_LIMIT = 8'h80;
    localparam logic [7:0] BYTE_LEAD_MIN    = 8'hC2;
    localparam logic [7:0] BYTE_LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] BYTE_LEAD_LIMIT  = 8'hF5;
    localparam logic [7:0] BYTE_E0          = 8'hE0;
    localparam logic [7:0] BYTE_ED          = 8'hED;
    localparam logic [7:0] BYTE_F0          = 8'hF0;
    localparam logic [7:0] BYTE_F4          = 8'hF4;
    localparam logic [7:0] CONT_MASK        = 8'hC0;
    localparam logic [7:0] CONT_TAG         = 8'h80;
    localparam logic [7:0] CONT_MIN         = 8'h80;
    localparam logic [7:0] CONT_MAX         = 8'hBF;
    localparam logic [7:0] CONT_E0_MIN      = 8'hA0;
    localparam logic [7:0] CONT_ED_MAX      = 8'h9F;
    localparam logic [7:0] CONT_F0_MIN      = 8'h90;
    localparam logic [7:0] CONT_F4_MAX      = 8'h8F;

    typedef struct packed {
        logic [1:0] pend;
        logic [2:0] chk;
        logic       err;
    } t_u8v_state;

    typedef struct packed {
        logic ok_so_far;
        logic string_done;
        logic string_valid;
    } t_u8v_result;

endpackage

>>> rtl/u8v_byte_if.sv
`timescale 1ns / 1ps

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/u8v_result_if.sv
`timescale 1ns / 1ps

interface u8v_result_if;
    logic valid;
    logic ready;
    logic ok_so_far;
    logic string_done;
    logic string_valid;

    modport source (output valid, output ok_so_far, output string_done,
                    output string_valid, input ready);
    modport sink (input valid, input ok_so_far, input string_done,
                  input string_valid, output ready);
endinterface

>>> rtl/u8v_decode.sv
`timescale 1ns / 1ps

module u8v_decode import u8v_pkg::*; (
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  t_u8v_state  i_state,
    output t_u8v_state  o_next_state,
    output t_u8v_result o_result
);

    logic       w_good;
    logic       w_err;
    logic       w_range_ok;
    logic [1:0] w_pend;
    logic [2:0] w_chk;

    always_comb begin
        w_range_ok = 1'b1;
        unique case (i_state.chk)
            CHK_E0: w_range_ok = (i_data_byte >= CONT_E0_MIN) && (i_data_byte <= CONT_MAX);
            CHK_ED: w_range_ok = (i_data_byte >= CONT_MIN) && (i_data_byte <= CONT_ED_MAX);
            CHK_F0: w_range_ok = (i_data_byte >= CONT_F0_MIN) && (i_data_byte <= CONT_MAX);
            CHK_F4: w_range_ok = (i_data_byte >= CONT_MIN) && (i_data_byte <= CONT_F4_MAX);
            default: w_range_ok = 1'b1;
        endcase
    end

    always_comb begin
        w_good = 1'b1;
        w_pend = i_state.pend;
        w_chk  = i_state.chk;
        if (i_state.pend != 2'd0) begin
            w_good = ((i_data_byte & CONT_MASK) == CONT_TAG) && w_range_ok;
            if (w_good) begin
                w_pend = i_state.pend - 2'd1;
                w_chk  = CHK_NONE;
            end
        end else if (i_data_byte < BYTE_ASCII_LIMIT) begin
            w_pend = 2'd0;
            w_chk  = CHK_NONE;
        end else if (i_data_byte < BYTE_LEAD_MIN || i_data_byte >= BYTE_LEAD_LIMIT) begin
            w_good = 1'b0;
        end else if (i_data_byte < BYTE_LEAD3_MIN) begin
            w_pend = 2'd1;
            w_chk  = CHK_NONE;
        end else if (i_data_byte < BYTE_LEAD4_MIN) begin
            w_pend = 2'd2;
            w_chk  = (i_data_byte == BYTE_E0) ? CHK_E0 :
                     (i_data_byte == BYTE_ED) ? CHK_ED : CHK_NONE;
        end else begin
            w_pend = 2'd3;
            w_chk  = (i_data_byte == BYTE_F0) ? CHK_F0 :
                     (i_data_byte == BYTE_F4) ? CHK_F4 : CHK_NONE;
        end
    end

    always_comb begin
        o_next_state = i_state;
        w_err = i_state.err;
        if (!i_state.err) begin
            w_err = !w_good || (i_last_byte && (w_pend != 2'd0));
            o_next_state.pend = w_err ? 2'd0 : w_pend;
            o_next_state.chk  = w_err ? CHK_NONE : w_chk;
        end
        o_next_state.err = w_err;
        if (i_last_byte) begin
            o_next_state = '0;
        end
        o_result.ok_so_far    = !w_err;
        o_result.string_done  = i_last_byte;
        o_result.string_valid = i_last_byte && !w_err;
    end

endmodule

>>> rtl/utf8_stream_validator.sv
`timescale 1ns / 1ps
// UTF-8 stream validator.
// The input channel i_byte carries one byte of a string per transaction, with
// last_byte marking its final byte. The output channel o_result carries one
// result per input byte: ok_so_far, string_done and string_valid.
// The result of a byte appears in the output register in the cycle after the
// byte is accepted.
// One byte is accepted per cycle unless the receiver stalls; the rate is set
// by the single decode stage between the character state and output registers.
// The input is ready whenever the output register is empty or is being
// taken in the same cycle, so a result that leaves in that cycle does not
// block a new byte.
// When the receiver stalls with a result waiting, ready drops and the byte
// is held by the sender until the result is taken.
// Reset clears the character state, the sticky error flag and the output
// valid flag. The final byte of each string also returns the state to reset.

module utf8_stream_validator import u8v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8v_byte_if.sink    i_byte,
    u8v_result_if.source o_result
);

    t_u8v_state  r_state;
    t_u8v_state  n_state;
    t_u8v_result r_res;
    t_u8v_result n_res;
    logic        r_out_valid;
    logic        w_accept;

    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;

    u8v_decode u_decode (
        .i_data_byte  (i_byte.data_byte),
        .i_last_byte  (i_byte.last_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.ok_so_far    = r_res.ok_so_far;
    assign o_result.string_done  = r_res.string_done;
    assign o_result.string_valid = r_res.string_valid;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_byte.last_byte) |=> (r_state == '0))
        else $error("State not cleared after the final byte of a string.");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err |-> (r_state.pend == 2'd0 && r_state.chk == CHK_NONE))
        else $error("Character state left pending after an error.");

    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.string_valid) |->
            (o_result.string_done && o_result.ok_so_far))
        else $error("Valid string reported without end mark or with an error.");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_state.err && !i_byte.last_byte) |=> r_state.err)
        else $error("Sticky error flag dropped before the end of a string.");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import u8v_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_utf8_byte;

    localparam int TOTAL_BYTES    = 1100;
    localparam int CALM_TAIL      = 120;
    localparam int STALL_LIMIT    = 1000;
    localparam int HOLD_START     = 500;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8v_byte_if   byte_ch();
    u8v_result_if res_ch();

    utf8_stream_validator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch.sink),
        .o_result (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_utf8_byte  byte_q[$];
    logic [7:0]  str_bytes[$];
    t_u8v_result expected_results[$];

    // Decoder state that mirrors the block.
    logic [1:0] dec_pend = 2'd0;
    logic [2:0] dec_chk  = CHK_NONE;
    logic       dec_err  = 1'b0;

    int bytes_sent   = 0;
    int results_seen = 0;
    int error_count  = 0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int hold_clock   = 0;
    int hold_left    = 0;
    int stall_cycles = 0;

    t_u8v_result got_result;
    t_u8v_result want_result;

    function automatic t_u8v_result validate_byte(logic [7:0] b, logic last);
        t_u8v_result r;
        logic err;
        logic good;
        err  = dec_err;
        good = 1'b1;
        if (!err) begin
            if (dec_pend != 2'd0) begin
                good = (b & CONT_MASK) == CONT_TAG;
                case (dec_chk)
                    CHK_E0: good = good && (b >= CONT_E0_MIN);
                    CHK_ED: good = good && (b <= CONT_ED_MAX);
                    CHK_F0: good = good && (b >= CONT_F0_MIN);
                    CHK_F4: good = good && (b <= CONT_F4_MAX);
                    default: ;
                endcase
                if (good) begin
                    dec_pend = dec_pend - 2'd1;
                    dec_chk  = CHK_NONE;
                end
            end else if (b < BYTE_ASCII_LIMIT) begin
                dec_chk = CHK_NONE;
            end else if (b < BYTE_LEAD_MIN || b >= BYTE_LEAD_LIMIT) begin
                good = 1'b0;
            end else if (b < BYTE_LEAD3_MIN) begin
                dec_pend = 2'd1;
                dec_chk  = CHK_NONE;
            end else if (b < BYTE_LEAD4_MIN) begin
                dec_pend = 2'd2;
                dec_chk  = (b == BYTE_E0) ? CHK_E0 : (b == BYTE_ED) ? CHK_ED : CHK_NONE;
            end else begin
                dec_pend = 2'd3;
                dec_chk  = (b == BYTE_F0) ? CHK_F0 : (b == BYTE_F4) ? CHK_F4 : CHK_NONE;
            end
            if (!good || (last && dec_pend != 2'd0)) begin
                err      = 1'b1;
                dec_pend = 2'd0;
                dec_chk  = CHK_NONE;
            end
        end
        r.ok_so_far    = !err;
        r.string_done  = last;
        r.string_valid = last && !err;
        if (last) begin
            dec_pend = 2'd0;
            dec_chk  = CHK_NONE;
            dec_err  = 1'b0;
        end else begin
            dec_err = err;
        end
        return r;
    endfunction

    function automatic logic [7:0] any_cont();
        return 8'($urandom_range(CONT_MIN, CONT_MAX));
    endfunction

    // Mostly a legal second byte for the lead, sometimes any continuation.
    function automatic logic [7:0] second_for(logic [7:0] lead);
        if ($urandom_range(0, 3) == 0)
            return any_cont();
        case (lead)
            BYTE_E0: return 8'($urandom_range(CONT_E0_MIN, CONT_MAX));
            BYTE_ED: return 8'($urandom_range(CONT_MIN, CONT_ED_MAX));
            BYTE_F0: return 8'($urandom_range(CONT_F0_MIN, CONT_MAX));
            BYTE_F4: return 8'($urandom_range(CONT_MIN, CONT_F4_MAX));
            default: return any_cont();
        endcase
    endfunction

    task automatic add_char();
        logic [7:0] lead;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            str_bytes.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 5) begin
            lead = 8'($urandom_range(BYTE_LEAD_MIN, LEAD2_MAX));
            str_bytes.push_back(lead);
            str_bytes.push_back(any_cont());
        end else if (kind < 8) begin
            if ($urandom_range(0, 2) == 0)
                lead = $urandom_range(0, 1) ? BYTE_E0 : BYTE_ED;
            else
                lead = 8'($urandom_range(BYTE_LEAD3_MIN, LEAD3_MAX));
            str_bytes.push_back(lead);
            str_bytes.push_back(second_for(lead));
            str_bytes.push_back(any_cont());
        end else begin
            lead = 8'($urandom_range(BYTE_LEAD4_MIN, BYTE_F4));
            str_bytes.push_back(lead);
            str_bytes.push_back(second_for(lead));
            str_bytes.push_back(any_cont());
            str_bytes.push_back(any_cont());
        end
    endtask

    task automatic flush_string();
        t_utf8_byte item;
        foreach (str_bytes[i]) begin
            item.b    = str_bytes[i];
            item.last = (i == str_bytes.size() - 1);
            byte_q.push_back(item);
        end
        str_bytes.delete();
    endtask

    task automatic add_random_string();
        int mode;
        int n;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) add_char();
            if (mode == 1)
                str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            else if (mode == 2 && str_bytes.size() > 1)
                str_bytes.delete(str_bytes.size() - 1);
        end
        flush_string();
    endtask

    // Byte source.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'h00;
            byte_ch.last_byte <= 1'b0;
            src_gap           <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                expected_results.push_back(validate_byte(byte_ch.data_byte, byte_ch.last_byte));
                void'(byte_q.pop_front());
                bytes_sent = bytes_sent + 1;
            end
            if (byte_ch.valid && !byte_ch.ready) begin
                // The offered transaction is held until it is taken.
            end else if (src_gap != 0) begin
                src_gap       <= src_gap - 1;
                byte_ch.valid <= 1'b0;
            end else if (byte_q.size() > CALM_TAIL && hold_left == 0
                         && ((bytes_sent / 100) % 3) != 0 && $urandom_range(0, 7) == 0) begin
                src_gap       <= $urandom_range(1, 9) - 1;
                byte_ch.valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= byte_q[0].b;
                byte_ch.last_byte <= byte_q[0].last;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_clock <= 0;
            hold_left  <= 0;
        end else begin
            hold_clock <= hold_clock + 1;
            if (hold_clock == HOLD_START)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // Result sink and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_gap     <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen = results_seen + 1;
                got_result.ok_so_far    = res_ch.ok_so_far;
                got_result.string_done  = res_ch.string_done;
                got_result.string_valid = res_ch.string_valid;
                if (expected_results.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("result %0d not expected: ok=%b done=%b valid=%b",
                                 results_seen, got_result.ok_so_far,
                                 got_result.string_done, got_result.string_valid);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.ok_so_far !== want_result.ok_so_far
                        || got_result.string_done !== want_result.string_done
                        || got_result.string_valid !== want_result.string_valid) begin
                        error_count = error_count + 1;
                        if (error_count <= MAX_REPORTS)
                            $display("result %0d: expected %b%b%b, got %b%b%b",
                                     results_seen, want_result.ok_so_far,
                                     want_result.string_done, want_result.string_valid,
                                     got_result.ok_so_far, got_result.string_done,
                                     got_result.string_valid);
                    end
                end
            end
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap     <= sink_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (byte_q.size() > CALM_TAIL && ((results_seen / 100) % 3) != 1
                         && $urandom_range(0, 7) == 0) begin
                sink_gap     <= $urandom_range(1, 9) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b0;

        str_bytes = '{8'h00};                      flush_string();
        str_bytes = '{8'hC2, 8'h80};               flush_string();
        str_bytes = '{8'hE0, 8'h9F, 8'h80};        flush_string();
        str_bytes = '{8'hED, 8'hA0};               flush_string();
        str_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80}; flush_string();
        str_bytes = '{8'hF4, 8'h90};               flush_string();
        str_bytes = '{8'hC1};                      flush_string();
        str_bytes = '{8'hFF};                      flush_string();
        str_bytes = '{8'h80};                      flush_string();
        str_bytes = '{8'hE2, 8'h82};               flush_string();
        str_bytes = '{8'hDF, 8'hBF, 8'h7F};        flush_string();
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; flush_string();
        while (byte_q.size() < TOTAL_BYTES)
            add_random_string();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
